FILE: hw/rtl/interacting_exclusion_ring_hop_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the exclusion ring hop block
// Clocked property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef INTERACTING_EXCLUSION_RING_HOP_ASSERT_SVH
`define INTERACTING_EXCLUSION_RING_HOP_ASSERT_SVH

// Check sampled on clk, switched off while rst is high.
`define IEH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check sampled on clk that also holds through reset.
`define IEH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/iehop_pkg.sv
// ----------------------------------------------------------------------------
// iehop_pkg
// Shared types and constants of the exclusion ring hop block.
// ----------------------------------------------------------------------------
`default_nettype none

package iehop_pkg;

  localparam int SITE_W     = 7;
  localparam int SITE_CODES = 2 ** SITE_W;
  localparam int THR_W      = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // about 0.01 as a fraction of 2^32
  localparam logic [THR_W-1:0] THRESH_RESET = 32'd42949673;
  localparam logic [CNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_HOP   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BASE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPULSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINDING   = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [SITE_W-1:0] site_index;
    logic              occupancy_value;
    logic [THR_W-1:0]  random_fraction;
    logic              measure_enable;
  } req_t;

  typedef struct packed {
    logic             hop_done;
    logic             site_occupied;
    logic [CNT_W-1:0] current_total;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_RD_PREV,
    ST_RD_SITE,
    ST_RD_NEXT,
    ST_RD_NNEXT,
    ST_DECIDE,
    ST_WR_NEXT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iehop_ring_mem.sv
// ----------------------------------------------------------------------------
// iehop_ring_mem
// Single-bit site occupancy RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iehop_ring_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/interacting_exclusion_ring_hop.sv
// ----------------------------------------------------------------------------
// interacting_exclusion_ring_hop
// Ring of site occupancies with threshold-gated particle hops and a
// saturating current counter at the middle site.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. A write
//   request stores one occupancy bit; a hop request moves the particle at
//   site_index to the next site when that site is empty and random_fraction
//   is at or below the threshold picked by the sites behind and two ahead.
//   Each request gives one result, shown for one cycle with done high; the
//   receiver cannot stall it. Thresholds are written through cfg_write,
//   cfg_index and cfg_data; the user must write them only while the block is
//   idle, which the block itself does not enforce. The occupancy RAM has a
//   single read port, so the four neighbor reads of a hop go out one per cycle
//   before the two write-backs. The next request may be accepted in the cycle
//   done is high.
//   Reset: thresholds return to about 0.01 and the counter to zero; then a
//   clearing pass empties every RAM site with busy held high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "interacting_exclusion_ring_hop_assert.svh"

module interacting_exclusion_ring_hop #(
  parameter int RING_SITES = 128
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire iehop_pkg::req_t                 req,
  output logic                                 done,
  output iehop_pkg::result_t                   result,
  input  wire logic                            cfg_write,
  input  wire logic [iehop_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iehop_pkg::THR_W-1:0]     cfg_data
);

  localparam int AW = $clog2(RING_SITES);
  localparam logic [AW-1:0] LAST_SITE = AW'(RING_SITES - 1);
  localparam logic [AW-1:0] MID_SITE  = AW'(RING_SITES / 2 - 1);

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] s);
    ring_inc = (s == LAST_SITE) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] s);
    ring_dec = (s == '0) ? LAST_SITE : s - AW'(1);
  endfunction

  iehop_pkg::state_t state, state_next;

  logic [iehop_pkg::THR_W-1:0] base_threshold;
  logic [iehop_pkg::THR_W-1:0] repulsion_threshold;
  logic [iehop_pkg::THR_W-1:0] binding_threshold;
  logic [iehop_pkg::CNT_W-1:0] hop_counter, hop_counter_next;

  iehop_pkg::req_t item;
  logic [AW-1:0]   site;
  logic [AW-1:0]   clr_addr;
  logic            occ_prev, occ_site, occ_next;
  logic            hopped;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic            mem_rdata;

  logic [iehop_pkg::THR_W-1:0] thr;
  logic                        hop_now;
  logic [AW-1:0]               site_next;

  // site_index reduced modulo the ring size, as a constant lookup
  logic [AW-1:0] site_map [iehop_pkg::SITE_CODES];

  for (genvar g = 0; g < iehop_pkg::SITE_CODES; g++) begin : g_site_map
    assign site_map[g] = AW'(g % RING_SITES);
  end

  assign site_next = ring_inc(site);

  iehop_ring_mem #(
    .DEPTH (RING_SITES),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // In ST_DECIDE the RAM output holds the site two ahead.
  always_comb begin
    if (occ_prev == mem_rdata) begin
      thr = base_threshold;
    end else if (occ_prev) begin
      thr = repulsion_threshold;
    end else begin
      thr = binding_threshold;
    end
    hop_now = occ_site && !occ_next && (item.random_fraction <= thr);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      iehop_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_SITE) state_next = iehop_pkg::ST_IDLE;
      end
      iehop_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (req.operation == iehop_pkg::OP_HOP) ?
                       iehop_pkg::ST_RD_PREV : iehop_pkg::ST_WRITE;
        end
      end
      iehop_pkg::ST_WRITE:    state_next = iehop_pkg::ST_IDLE;
      iehop_pkg::ST_RD_PREV:  state_next = iehop_pkg::ST_RD_SITE;
      iehop_pkg::ST_RD_SITE:  state_next = iehop_pkg::ST_RD_NEXT;
      iehop_pkg::ST_RD_NEXT:  state_next = iehop_pkg::ST_RD_NNEXT;
      iehop_pkg::ST_RD_NNEXT: state_next = iehop_pkg::ST_DECIDE;
      iehop_pkg::ST_DECIDE:   state_next = iehop_pkg::ST_WR_NEXT;
      iehop_pkg::ST_WR_NEXT:  state_next = iehop_pkg::ST_IDLE;
      default:                state_next = iehop_pkg::ST_IDLE;
    endcase
  end

  // RAM control and busy
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = site;
    mem_wdata = 1'b0;
    mem_raddr = site;
    unique case (state)
      iehop_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      iehop_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      iehop_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = item.occupancy_value;
      end
      iehop_pkg::ST_RD_PREV:  mem_raddr = ring_dec(site);
      iehop_pkg::ST_RD_SITE:  mem_raddr = site;
      iehop_pkg::ST_RD_NEXT:  mem_raddr = site_next;
      iehop_pkg::ST_RD_NNEXT: mem_raddr = ring_inc(site_next);
      iehop_pkg::ST_DECIDE: begin
        mem_we = hop_now;
      end
      iehop_pkg::ST_WR_NEXT: begin
        mem_we    = hopped;
        mem_waddr = site_next;
        mem_wdata = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    hop_counter_next = hop_counter;
    if (state == iehop_pkg::ST_WR_NEXT && hopped && site == MID_SITE &&
        item.measure_enable && hop_counter != iehop_pkg::COUNT_MAX) begin
      hop_counter_next = hop_counter + iehop_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= iehop_pkg::ST_CLEAR;
      clr_addr            <= '0;
      hop_counter         <= '0;
      base_threshold      <= iehop_pkg::THRESH_RESET;
      repulsion_threshold <= iehop_pkg::THRESH_RESET;
      binding_threshold   <= iehop_pkg::THRESH_RESET;
      done                <= 1'b0;
    end else begin
      state       <= state_next;
      hop_counter <= hop_counter_next;
      done        <= (state == iehop_pkg::ST_WRITE) || (state == iehop_pkg::ST_WR_NEXT);
      if (state == iehop_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cfg_write) begin
        case (cfg_index)
          iehop_pkg::REG_BASE:      base_threshold      <= cfg_data;
          iehop_pkg::REG_REPULSION: repulsion_threshold <= cfg_data;
          iehop_pkg::REG_BINDING:   binding_threshold   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Request capture, neighbor samples and result payload
  always_ff @(posedge clk) begin
    if (state == iehop_pkg::ST_IDLE && start) begin
      item <= req;
      site <= site_map[req.site_index];
    end
    if (state == iehop_pkg::ST_RD_SITE)  occ_prev <= mem_rdata;
    if (state == iehop_pkg::ST_RD_NEXT)  occ_site <= mem_rdata;
    if (state == iehop_pkg::ST_RD_NNEXT) occ_next <= mem_rdata;
    if (state == iehop_pkg::ST_DECIDE)   hopped   <= hop_now;
    if (state == iehop_pkg::ST_WRITE) begin
      result.hop_done      <= 1'b0;
      result.site_occupied <= item.occupancy_value;
      result.current_total <= hop_counter;
    end
    if (state == iehop_pkg::ST_WR_NEXT) begin
      result.hop_done      <= hopped;
      result.site_occupied <= occ_site && !hopped;
      result.current_total <= hop_counter_next;
    end
  end

  `IEH_ASSERT(a_done_single, done |=> !done, "done held longer than one cycle")
  `IEH_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request accepted without going busy")
  `IEH_ASSERT(a_hop_vacates, (done && result.hop_done) |-> !result.site_occupied,
    "hop result reports the source site still occupied")
  `IEH_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done, "result strobe right after reset")

endmodule

`default_nettype wire

FILE: sim/interacting_exclusion_ring_hop_test.sv
// ----------------------------------------------------------------------------
// interacting_exclusion_ring_hop_test
// Self-checking bench for the exclusion ring hop block. A scoreboard keeps
// its own ring, counter and thresholds, predicts the result of every accepted
// request and compares each strobed result field by field. Requests come in
// bursts, with random gaps in all but one run, under several threshold settings.
// ----------------------------------------------------------------------------
module interacting_exclusion_ring_hop_test;

  localparam int   SITE_CODES   = iehop_pkg::SITE_CODES;
  localparam logic OP_WRITE     = iehop_pkg::OP_WRITE;
  localparam logic OP_HOP       = iehop_pkg::OP_HOP;
  localparam int   MID_SITE     = SITE_CODES / 2 - 1;
  localparam int   REPORT_LIMIT = 10;

  class hop_ledger;
    bit [SITE_CODES-1:0]          occupancy;
    bit [iehop_pkg::CNT_W-1:0]    hop_total;
    bit [iehop_pkg::THR_W-1:0]    threshold [3];
    iehop_pkg::result_t           expected_results [$];
    int                           errors;
    int                           requests;
    int                           results_seen;
    int                           moves;
    int                           counted;

    function new();
      occupancy = '0;
      hop_total = '0;
      foreach (threshold[i]) threshold[i] = iehop_pkg::THRESH_RESET;
      errors = 0;
      requests = 0;
      results_seen = 0;
      moves = 0;
      counted = 0;
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endfunction

    function void note_request(iehop_pkg::req_t r);
      iehop_pkg::result_t           res;
      bit [iehop_pkg::SITE_W-1:0]   s;
      bit [iehop_pkg::SITE_W-1:0]   behind;
      bit [iehop_pkg::SITE_W-1:0]   ahead;
      bit [iehop_pkg::SITE_W-1:0]   ahead2;
      bit [iehop_pkg::THR_W-1:0]    thr;
      s = r.site_index;
      // 7-bit index math wraps around the 128-site ring
      behind = s - 1'b1;
      ahead = s + 1'b1;
      ahead2 = s + 2'd2;
      res = '0;
      requests++;
      if (r.operation == OP_WRITE) begin
        occupancy[s] = r.occupancy_value;
      end else if (occupancy[s] && !occupancy[ahead]) begin
        if (occupancy[behind] == occupancy[ahead2]) thr = threshold[iehop_pkg::REG_BASE];
        else if (occupancy[behind]) thr = threshold[iehop_pkg::REG_REPULSION];
        else thr = threshold[iehop_pkg::REG_BINDING];
        if (r.random_fraction <= thr) begin
          occupancy[s] = 1'b0;
          occupancy[ahead] = 1'b1;
          res.hop_done = 1'b1;
          moves++;
          if (s == MID_SITE && r.measure_enable && hop_total != iehop_pkg::COUNT_MAX) begin
            hop_total++;
            counted++;
          end
        end
      end
      res.site_occupied = occupancy[s];
      res.current_total = hop_total;
      expected_results.push_back(res);
    endfunction

    function void check_result(iehop_pkg::result_t got);
      iehop_pkg::result_t want;
      results_seen++;
      if (expected_results.size() == 0) begin
        complain($sformatf("result %0d with no request pending: hop=%0b occ=%0b total=%0d",
                           results_seen, got.hop_done, got.site_occupied,
                           got.current_total));
        return;
      end
      want = expected_results.pop_front();
      if (got.hop_done !== want.hop_done || got.site_occupied !== want.site_occupied ||
          got.current_total !== want.current_total)
        complain($sformatf({"result %0d: expected hop=%0b occ=%0b total=%0d, ",
                            "got hop=%0b occ=%0b total=%0d"},
                           results_seen, want.hop_done, want.site_occupied,
                           want.current_total, got.hop_done, got.site_occupied,
                           got.current_total));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            start;
  logic                            busy;
  iehop_pkg::req_t                 req;
  logic                            done;
  iehop_pkg::result_t              result;
  logic                            cfg_write;
  logic [iehop_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [iehop_pkg::THR_W-1:0]     cfg_data;

  hop_ledger       ledger;
  iehop_pkg::req_t directed [$];
  int              settings_used;

  interacting_exclusion_ring_hop #(
    .RING_SITES(SITE_CODES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // results first: a request may be taken in the cycle the previous one is done
  always @(posedge clk) begin
    if (!rst) begin
      if (done) ledger.check_result(result);
      if (start && !busy) ledger.note_request(req);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still expected", ledger.expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic iehop_pkg::req_t make_req(input logic op, input int site,
                                               input logic occ,
                                               input logic [iehop_pkg::THR_W-1:0] frac,
                                               input logic meas);
    iehop_pkg::req_t r;
    r.operation = op;
    r.site_index = iehop_pkg::SITE_W'(site);
    r.occupancy_value = occ;
    r.random_fraction = frac;
    r.measure_enable = meas;
    return r;
  endfunction

  function automatic iehop_pkg::req_t random_request();
    iehop_pkg::req_t             r;
    int                          pick;
    logic [iehop_pkg::THR_W-1:0] thr;
    r.operation = ($urandom_range(99) < 65) ? OP_HOP : OP_WRITE;
    pick = $urandom_range(9);
    // lean on the middle site and the wrap point
    if (pick < 3) r.site_index = iehop_pkg::SITE_W'(MID_SITE - 2 + $urandom_range(4));
    else if (pick < 4) r.site_index = iehop_pkg::SITE_W'(SITE_CODES - 2 + $urandom_range(3));
    else r.site_index = iehop_pkg::SITE_W'($urandom());
    r.occupancy_value = $urandom_range(99) < 55;
    thr = ledger.threshold[$urandom_range(2)];
    case ($urandom_range(9))
      0: r.random_fraction = '0;
      1: r.random_fraction = '1;
      2: r.random_fraction = thr;
      3: r.random_fraction = thr + 1'b1;
      4: r.random_fraction = thr - 1'b1;
      default: r.random_fraction = $urandom();
    endcase
    r.measure_enable = $urandom_range(3) != 0;
    return r;
  endfunction

  task automatic send_request(input iehop_pkg::req_t r);
    start = 1'b1;
    req = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (ledger.expected_results.size() != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [iehop_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [iehop_pkg::THR_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    ledger.threshold[idx] = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic apply_setting(input logic [iehop_pkg::THR_W-1:0] base,
                               input logic [iehop_pkg::THR_W-1:0] repel,
                               input logic [iehop_pkg::THR_W-1:0] binding);
    write_threshold(iehop_pkg::REG_BASE, base);
    write_threshold(iehop_pkg::REG_REPULSION, repel);
    write_threshold(iehop_pkg::REG_BINDING, binding);
    settings_used++;
  endtask

  task automatic run_random(input int count, input bit gappy);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(random_request());
        sent++;
      end
      if (gappy && $urandom_range(3) != 0) hold_off($urandom_range(1, 9));
    end
  endtask

  initial begin
    ledger = new();
    settings_used = 1;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // busy stays high through the clearing pass
    wait_idle();

    run_random(100, 1'b1);
    wait_idle();

    apply_setting('0, '1, 32'h8000_0000);
    directed.push_back(make_req(OP_HOP,   MID_SITE,     1'b0, '0, 1'b1));  // empty site
    directed.push_back(make_req(OP_WRITE, MID_SITE,     1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_WRITE, MID_SITE + 1, 1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   MID_SITE,     1'b0, '0, 1'b1));  // blocked
    directed.push_back(make_req(OP_WRITE, MID_SITE + 1, 1'b0, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   MID_SITE,     1'b0, '0, 1'b1));  // zero threshold hops
    directed.push_back(make_req(OP_WRITE, MID_SITE,     1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_WRITE, MID_SITE + 1, 1'b0, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   MID_SITE,     1'b0, 32'd1, 1'b1));
    directed.push_back(make_req(OP_WRITE, MID_SITE - 1, 1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   MID_SITE,     1'b0, '1, 1'b0));  // repulsion, unmeasured
    directed.push_back(make_req(OP_WRITE, SITE_CODES - 1, 1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_WRITE, 0, 1'b0, '0, 1'b0));
    directed.push_back(make_req(OP_WRITE, 1, 1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   SITE_CODES - 1, 1'b0, 32'h8000_0000, 1'b1));
    directed.push_back(make_req(OP_HOP,   0, 1'b0, 32'h8000_0001, 1'b1));
    directed.push_back(make_req(OP_WRITE, 1, 1'b0, '0, 1'b0));
    directed.push_back(make_req(OP_WRITE, 2, 1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   0, 1'b0, 32'h8000_0001, 1'b1));  // binding, miss
    directed.push_back(make_req(OP_HOP,   0, 1'b0, 32'h8000_0000, 1'b1));  // binding, hit
    directed.push_back(make_req(OP_WRITE, SITE_CODES - 2, 1'b1, '0, 1'b0));
    directed.push_back(make_req(OP_HOP,   SITE_CODES - 2, 1'b0, '0, 1'b1));
    directed.push_back(make_req(OP_WRITE, 5, 1'b1, '1, 1'b1));  // write ignores extras
    directed.push_back(make_req(OP_HOP,   MID_SITE,     1'b1, '1, 1'b1));
    directed.push_back(make_req(OP_WRITE, MID_SITE,     1'b0, '1, 1'b1));
    foreach (directed[i]) send_request(directed[i]);
    wait_idle();

    apply_setting('1, '1, '1);
    run_random(190, 1'b1);
    wait_idle();

    apply_setting('0, '0, '0);
    run_random(170, 1'b1);
    wait_idle();

    apply_setting($urandom(), $urandom(), $urandom());
    run_random(190, 1'b0);
    wait_idle();

    apply_setting(32'h8000_0000, 32'h4000_0000, 32'hC000_0000);
    run_random(180, 1'b1);
    wait_idle();

    repeat (10) @(posedge clk);
    $display("Covered %0d requests under %0d threshold settings: %0d hops, %0d counted%s",
             ledger.requests, settings_used, ledger.moves, ledger.counted,
             " at mid site.");
    $display("%0d results checked, %0d errors, %0d results missing.",
             ledger.results_seen, ledger.errors, ledger.expected_results.size());
    if (ledger.errors == 0 && ledger.expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
